// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the preamble detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: property violated");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/core/ncpd_pkg.sv =====
// Types, constants and helpers of the normalized correlation preamble detector.
package ncpd_pkg;

	localparam int PREAMBLE_LEN = 32;
	localparam int SAMPLE_WIDTH = 16;
	localparam int IDX_W        = $clog2(PREAMBLE_LEN);
	localparam int TAP_W        = 5;
	localparam int ACTION_W     = 2;
	localparam int THR_W        = 16;
	localparam int FLEN_W       = 13;
	localparam int FLEN_MAX     = 4096;
	localparam int OFS_W        = 12;
	localparam int SCORE_W      = 16;
	localparam int CFG_DATA_W   = 16;

	localparam int S_TDATA_W = ((TAP_W + 2 * SAMPLE_WIDTH) + 7) / 8 * 8;
	localparam int M_PAY_W   = OFS_W + SCORE_W + 2 * SAMPLE_WIDTH;
	localparam int M_TDATA_W = (M_PAY_W + 7) / 8 * 8;

	// Arithmetic widths: correlation sums, window power and the ratio test.
	localparam int PROD_W    = 2 * SAMPLE_WIDTH;
	localparam int ACC_W     = 2 * SAMPLE_WIDTH + IDX_W + 1;
	localparam int POW_W     = 2 * SAMPLE_WIDTH + IDX_W;
	localparam int MAG_W     = ACC_W - 1;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUMSQ_W   = SQ_W + 1;
	localparam int NUM_SHIFT = (2 * SAMPLE_WIDTH < 34) ? (34 - 2 * SAMPLE_WIDTH) : 0;
	localparam int DEN_SHIFT = (2 * SAMPLE_WIDTH > 34) ? (2 * SAMPLE_WIDTH - 34) : 0;
	localparam int NUM_W     = SUMSQ_W + IDX_W + 1 + NUM_SHIFT;
	localparam int DEN_W     = POW_W + DEN_SHIFT;
	localparam int QUO_W     = 2 * SCORE_W;
	localparam int ARC_W     = $clog2(NUM_W + SQ_W);

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NOP    = 2'd3
	} act_t;

	typedef enum logic {
		CFG_THRESHOLD = 1'b0,
		CFG_FRAME_LEN = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_LAUNCH,
		ST_CALC,
		ST_EMIT
	} st_t;

	typedef enum logic [2:0] {
		AR_IDLE,
		AR_SQ,
		AR_NUM,
		AR_DIV,
		AR_ROOT,
		AR_DONE
	} ar_st_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] im;
		logic signed [SAMPLE_WIDTH-1:0] re;
	} cplx_t;

	typedef struct packed {
		logic clear;
		logic win_adv;
		logic tap_adv;
		logic cap_adv;
	} cell_ctl_t;

	typedef struct packed {
		logic               done;
		logic               detect;
		logic [SCORE_W-1:0] score;
	} ar_res_t;

	function automatic logic [MAG_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] u;
		u = v[ACC_W-1] ? (ACC_W'(0) - ACC_W'(v)) : ACC_W'(v);
		return u[MAG_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ncpd_cell.sv =====
// One cell of the chain: a template tap, a window sample and a capture sample.
module ncpd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ncpd_pkg::cell_ctl_t ctl,
	input  logic                tap_we,
	input  ncpd_pkg::cplx_t     tap_in,
	input  ncpd_pkg::cplx_t     tap_prev,
	input  ncpd_pkg::cplx_t     win_in,
	input  ncpd_pkg::cplx_t     cap_in,
	output ncpd_pkg::cplx_t     tap,
	output ncpd_pkg::cplx_t     win,
	output ncpd_pkg::cplx_t     cap
);

	ncpd_pkg::cplx_t tap_q;
	ncpd_pkg::cplx_t win_q;
	ncpd_pkg::cplx_t cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			win_q <= '0;
			cap_q <= '0;
		end else begin
			// clear drops history but keeps the taps
			if (ctl.clear) begin
				win_q <= '0;
				cap_q <= '0;
			end else begin
				if (ctl.win_adv) begin
					win_q <= win_in;
				end
				if (ctl.cap_adv) begin
					cap_q <= cap_in;
				end
			end
			if (tap_we) begin
				tap_q <= tap_in;
			end else if (ctl.tap_adv) begin
				tap_q <= tap_prev;
			end
		end
	end

	assign tap = tap_q;
	assign win = win_q;
	assign cap = cap_q;

endmodule

// ===== rtl/core/ncpd_arith.sv =====
// Sequential ratio unit: |c|^2 by shift-add, restoring divide by power, bitwise root.
`include "assert_macros.svh"
module ncpd_arith (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [ncpd_pkg::ACC_W-1:0]      cre,
	input  logic signed [ncpd_pkg::ACC_W-1:0]      cim,
	input  logic        [ncpd_pkg::POW_W-1:0]      pow,
	input  logic        [ncpd_pkg::THR_W-1:0]      thr,
	output ncpd_pkg::ar_res_t                      res
);

	ncpd_pkg::ar_st_t ast_q, ast_d;

	logic [ncpd_pkg::ARC_W-1:0]   cnt_q;
	logic [ncpd_pkg::SQ_W-1:0]    mcand_q;
	logic [ncpd_pkg::MAG_W-1:0]   mplier_q;
	logic [ncpd_pkg::MAG_W-1:0]   mim_q;
	logic [ncpd_pkg::SUMSQ_W-1:0] sumsq_q;
	logic [ncpd_pkg::NUM_W-1:0]   num_q;
	logic [ncpd_pkg::DEN_W-1:0]   den_q;
	logic [ncpd_pkg::DEN_W-1:0]   rem_q;
	logic [ncpd_pkg::QUO_W-1:0]   quo_q;
	logic [ncpd_pkg::QUO_W-1:0]   t2_q;
	logic [ncpd_pkg::SCORE_W-1:0] score_q;
	logic [ncpd_pkg::SCORE_W-1:0] bit_q;
	logic                         sat_q;
	logic                         pow0_q;

	logic [ncpd_pkg::DEN_W:0]     trial;
	logic                         trial_ge;
	logic [ncpd_pkg::SCORE_W-1:0] cand;
	logic [ncpd_pkg::QUO_W-1:0]   cand_sq;
	logic                         sq_half;
	logic                         sq_end;
	logic                         div_end;

	assign trial    = {rem_q, num_q[ncpd_pkg::NUM_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};
	assign cand     = score_q | bit_q;
	assign cand_sq  = cand * cand;
	assign sq_half  = cnt_q == ncpd_pkg::ARC_W'(ncpd_pkg::MAG_W - 1);
	assign sq_end   = cnt_q == ncpd_pkg::ARC_W'(2 * ncpd_pkg::MAG_W - 1);
	assign div_end  = cnt_q == ncpd_pkg::ARC_W'(ncpd_pkg::NUM_W - 1);

	always_comb begin
		ast_d = ast_q;
		case (ast_q)
			ncpd_pkg::AR_IDLE: begin
				if (start) begin
					ast_d = (pow == '0) ? ncpd_pkg::AR_DONE : ncpd_pkg::AR_SQ;
				end
			end
			ncpd_pkg::AR_SQ:   if (sq_end) ast_d = ncpd_pkg::AR_NUM;
			ncpd_pkg::AR_NUM:  ast_d = ncpd_pkg::AR_DIV;
			ncpd_pkg::AR_DIV:  if (div_end) ast_d = ncpd_pkg::AR_ROOT;
			ncpd_pkg::AR_ROOT: if (bit_q[0]) ast_d = ncpd_pkg::AR_DONE;
			ncpd_pkg::AR_DONE: ast_d = ncpd_pkg::AR_IDLE;
			default:           ast_d = ncpd_pkg::AR_IDLE;
		endcase
	end

	always_comb begin
		res.done   = ast_q == ncpd_pkg::AR_DONE;
		res.detect = !pow0_q && (sat_q || (quo_q > t2_q) ||
			((quo_q == t2_q) && (rem_q != '0)));
		res.score  = sat_q ? '1 : score_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ast_q <= ncpd_pkg::AR_IDLE;
		end else begin
			ast_q <= ast_d;
		end
	end

	always_ff @(posedge clk) begin
		case (ast_q)
			ncpd_pkg::AR_IDLE: begin
				if (start) begin
					pow0_q   <= pow == '0;
					mcand_q  <= ncpd_pkg::SQ_W'(ncpd_pkg::mag_acc(cre));
					mplier_q <= ncpd_pkg::mag_acc(cre);
					mim_q    <= ncpd_pkg::mag_acc(cim);
					sumsq_q  <= '0;
					cnt_q    <= '0;
					den_q    <= ncpd_pkg::DEN_W'(pow) << ncpd_pkg::DEN_SHIFT;
					t2_q     <= thr * thr;
				end
			end
			ncpd_pkg::AR_SQ: begin
				if (mplier_q[0]) begin
					sumsq_q <= sumsq_q + ncpd_pkg::SUMSQ_W'(mcand_q);
				end
				// switch to the imaginary magnitude halfway through
				if (sq_half) begin
					mcand_q  <= ncpd_pkg::SQ_W'(mim_q);
					mplier_q <= mim_q;
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			ncpd_pkg::AR_NUM: begin
				num_q <= (ncpd_pkg::NUM_W'(sumsq_q) *
					ncpd_pkg::NUM_W'(ncpd_pkg::PREAMBLE_LEN)) << ncpd_pkg::NUM_SHIFT;
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				cnt_q <= '0;
			end
			ncpd_pkg::AR_DIV: begin
				rem_q <= trial_ge ? ncpd_pkg::DEN_W'(trial - {1'b0, den_q}) :
					ncpd_pkg::DEN_W'(trial);
				// quotient bits beyond the low word only mark saturation
				sat_q   <= sat_q | quo_q[ncpd_pkg::QUO_W-1];
				quo_q   <= {quo_q[ncpd_pkg::QUO_W-2:0], trial_ge};
				num_q   <= num_q << 1;
				cnt_q   <= cnt_q + 1'b1;
				score_q <= '0;
				bit_q   <= {1'b1, {(ncpd_pkg::SCORE_W - 1){1'b0}}};
			end
			ncpd_pkg::AR_ROOT: begin
				if (cand_sq <= quo_q) begin
					score_q <= cand;
				end
				bit_q <= bit_q >> 1;
			end
			default: begin
			end
		endcase
	end

	`ASSERT_AT(a_det_needs_power, clk, arst_n, (res.done && res.detect) |-> !pow0_q)
	`ASSERT_AT(a_sat_full_score, clk, arst_n, (res.done && sat_q) |-> (res.score == '1))
	`ASSERT_AT(a_root_bound, clk, arst_n,
		(res.done && !sat_q && !pow0_q) |-> ((score_q * score_q) <= quo_q))

endmodule

// ===== rtl/core/normalized_correlation_preamble_detector.sv =====
// Top level of the normalized correlation preamble detector.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tuser action; tdata tap_index, value_re, value_im
//  m_        out  m_tvalid/m_tready    tdata offset, score, preamble_re, preamble_im; tlast
//  cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Tap loads, clears and samples arriving after a detection in the same frame are taken
// while the block stays idle. A searched sample rotates the cell chain past the shared
// multiply-accumulate, then the ratio unit runs its shift-add square, restoring divide
// and bitwise root, skipping them all when the window power is zero. A detection adds
// 32 result transfers; input is held until all are loaded into the output register,
// so a stalled output stalls the input. Reset clears taps, window, capture history and
// frame position and sets the configuration to its defaults. cfg_ready is always high.
`include "assert_macros.svh"
module normalized_correlation_preamble_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tap_index, value_re, value_im from bit 0 up, zero padded
	input  logic [ncpd_pkg::S_TDATA_W-1:0]       s_tdata,
	// action
	input  logic [ncpd_pkg::ACTION_W-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// offset, score, preamble_re, preamble_im from bit 0 up, zero padded
	output logic [ncpd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [ncpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PL = ncpd_pkg::PREAMBLE_LEN;
	localparam int SW = ncpd_pkg::SAMPLE_WIDTH;

	ncpd_pkg::st_t st_q, st_d;

	// input decode
	ncpd_pkg::act_t             act;
	logic [ncpd_pkg::TAP_W-1:0] tap_idx;
	ncpd_pkg::cplx_t            x_in;
	logic                       acc_in;
	logic                       take_sample;
	logic                       search;

	// cell chain
	ncpd_pkg::cell_ctl_t ctl;
	ncpd_pkg::cplx_t     tap_w [PL];
	ncpd_pkg::cplx_t     win_w [PL];
	ncpd_pkg::cplx_t     cap_w [PL];
	ncpd_pkg::cplx_t     win_head;
	ncpd_pkg::cplx_t     cap_head;
	logic [PL-1:0]       tap_we;

	// multiply-accumulate at the tail of the chain
	logic signed [ncpd_pkg::PROD_W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [ncpd_pkg::PROD_W-1:0] q_r_s1, q_i_s1;
	logic                               pv_s1;
	logic signed [ncpd_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
	logic        [ncpd_pkg::POW_W-1:0]  pow_q;

	logic [ncpd_pkg::IDX_W-1:0] cnt_q;
	logic                       cnt_last;
	logic                       emit_load;

	ncpd_pkg::ar_res_t          ar_res;
	logic                       ar_start;

	// frame and configuration
	logic [ncpd_pkg::THR_W-1:0]   thr_q;
	logic [ncpd_pkg::FLEN_W-1:0]  flen_q;
	logic [ncpd_pkg::FLEN_W-1:0]  flen_eff;
	logic [ncpd_pkg::OFS_W-1:0]   fp_q;
	logic [ncpd_pkg::FLEN_W-1:0]  fp_inc;
	logic                         wrap;
	logic                         found_q;
	logic                         frame_step;
	logic                         calc_done;
	logic [ncpd_pkg::OFS_W-1:0]   offset_q;
	logic [ncpd_pkg::SCORE_W-1:0] score_q;

	// output register
	logic                         m_tvalid_q;
	logic [ncpd_pkg::M_PAY_W-1:0] m_pay_q;
	logic                         m_tlast_q;

	assign act     = ncpd_pkg::act_t'(s_tuser);
	assign tap_idx = s_tdata[ncpd_pkg::TAP_W-1:0];
	assign x_in.re = s_tdata[ncpd_pkg::TAP_W +: SW];
	assign x_in.im = s_tdata[ncpd_pkg::TAP_W + SW +: SW];

	assign s_tready    = st_q == ncpd_pkg::ST_IDLE;
	assign acc_in      = s_tvalid && s_tready;
	assign take_sample = acc_in && (act == ncpd_pkg::ACT_SAMPLE);
	assign search      = take_sample && !found_q;
	assign cnt_last    = cnt_q == ncpd_pkg::IDX_W'(PL - 1);
	assign emit_load   = (st_q == ncpd_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);
	assign calc_done   = (st_q == ncpd_pkg::ST_CALC) && ar_res.done;
	assign ar_start    = st_q == ncpd_pkg::ST_LAUNCH;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ncpd_pkg::ST_IDLE:   if (search) st_d = ncpd_pkg::ST_MAC;
			ncpd_pkg::ST_MAC:    if (cnt_last) st_d = ncpd_pkg::ST_DRAIN;
			ncpd_pkg::ST_DRAIN:  st_d = ncpd_pkg::ST_LAUNCH;
			ncpd_pkg::ST_LAUNCH: st_d = ncpd_pkg::ST_CALC;
			ncpd_pkg::ST_CALC: begin
				if (ar_res.done) begin
					st_d = ar_res.detect ? ncpd_pkg::ST_EMIT : ncpd_pkg::ST_IDLE;
				end
			end
			ncpd_pkg::ST_EMIT:   if (emit_load && cnt_last) st_d = ncpd_pkg::ST_IDLE;
			default:             st_d = ncpd_pkg::ST_IDLE;
		endcase
	end

	// chain control: a new sample enters at the head, otherwise the tail wraps
	// around so a full rotation leaves every cell where it started
	always_comb begin
		ctl.clear   = acc_in && (act == ncpd_pkg::ACT_CLEAR);
		ctl.win_adv = take_sample || (st_q == ncpd_pkg::ST_MAC);
		ctl.tap_adv = st_q == ncpd_pkg::ST_MAC;
		ctl.cap_adv = search || emit_load;
		win_head    = (st_q == ncpd_pkg::ST_IDLE) ? x_in : win_w[PL-1];
		cap_head    = (st_q == ncpd_pkg::ST_IDLE) ? x_in : cap_w[PL-1];
		for (int k = 0; k < PL; k++) begin
			tap_we[k] = acc_in && (act == ncpd_pkg::ACT_LOAD) &&
				(tap_idx == ncpd_pkg::TAP_W'(k));
		end
	end

	for (genvar k = 0; k < PL; k++) begin : g_cell
		if (k == 0) begin : g_head
			ncpd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.tap_we   (tap_we[k]),
				.tap_in   (x_in),
				.tap_prev (tap_w[PL-1]),
				.win_in   (win_head),
				.cap_in   (cap_head),
				.tap      (tap_w[k]),
				.win      (win_w[k]),
				.cap      (cap_w[k])
			);
		end else begin : g_body
			ncpd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.tap_we   (tap_we[k]),
				.tap_in   (x_in),
				.tap_prev (tap_w[k-1]),
				.win_in   (win_w[k-1]),
				.cap_in   (cap_w[k-1]),
				.tap      (tap_w[k]),
				.win      (win_w[k]),
				.cap      (cap_w[k])
			);
		end
	end

	ncpd_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ar_start),
		.cre    (acc_re_q),
		.cim    (acc_im_q),
		.pow    (pow_q),
		.thr    (thr_q),
		.res    (ar_res)
	);

	// frame bookkeeping: out-of-range lengths clamp to one and to the maximum
	always_comb begin
		if (flen_q == '0) begin
			flen_eff = ncpd_pkg::FLEN_W'(1);
		end else if (flen_q > ncpd_pkg::FLEN_W'(ncpd_pkg::FLEN_MAX)) begin
			flen_eff = ncpd_pkg::FLEN_W'(ncpd_pkg::FLEN_MAX);
		end else begin
			flen_eff = flen_q;
		end
		fp_inc     = ncpd_pkg::FLEN_W'(fp_q) + 1'b1;
		wrap       = fp_inc >= flen_eff;
		frame_step = (take_sample && found_q) || calc_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ncpd_pkg::ST_IDLE;
			cnt_q      <= '0;
			pv_s1      <= 1'b0;
			fp_q       <= '0;
			found_q    <= 1'b0;
			thr_q      <= ncpd_pkg::THR_W'(52429);
			flen_q     <= ncpd_pkg::FLEN_W'(64);
			m_tvalid_q <= 1'b0;
			acc_re_q   <= '0;
			acc_im_q   <= '0;
			pow_q      <= '0;
		end else begin
			st_q  <= st_d;
			pv_s1 <= st_q == ncpd_pkg::ST_MAC;
			if ((st_q == ncpd_pkg::ST_MAC) || emit_load) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end

			// start fresh sums for each searched sample
			if (search) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
				pow_q    <= '0;
			end else if (pv_s1) begin
				acc_re_q <= acc_re_q + ncpd_pkg::ACC_W'(p_rr_s1) - ncpd_pkg::ACC_W'(p_ii_s1);
				acc_im_q <= acc_im_q + ncpd_pkg::ACC_W'(p_ri_s1) + ncpd_pkg::ACC_W'(p_ir_s1);
				pow_q    <= pow_q + ncpd_pkg::POW_W'(unsigned'(q_r_s1)) +
					ncpd_pkg::POW_W'(unsigned'(q_i_s1));
			end

			if (ctl.clear) begin
				fp_q    <= '0;
				found_q <= 1'b0;
			end else if (frame_step) begin
				// a wrap ends the frame and re-arms detection
				fp_q    <= wrap ? '0 : fp_inc[ncpd_pkg::OFS_W-1:0];
				found_q <= wrap ? 1'b0 : (found_q || (calc_done && ar_res.detect));
			end

			if (cfg_valid && cfg_ready) begin
				case (ncpd_pkg::cfg_idx_t'(cfg_index))
					ncpd_pkg::CFG_THRESHOLD: thr_q  <= cfg_data[ncpd_pkg::THR_W-1:0];
					ncpd_pkg::CFG_FRAME_LEN: flen_q <= cfg_data[ncpd_pkg::FLEN_W-1:0];
					default: begin
					end
				endcase
			end

			if (emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// product, result and payload registers
	always_ff @(posedge clk) begin
		p_rr_s1 <= tap_w[PL-1].re * win_w[PL-1].re;
		p_ii_s1 <= tap_w[PL-1].im * win_w[PL-1].im;
		p_ri_s1 <= tap_w[PL-1].re * win_w[PL-1].im;
		p_ir_s1 <= tap_w[PL-1].im * win_w[PL-1].re;
		q_r_s1  <= win_w[PL-1].re * win_w[PL-1].re;
		q_i_s1  <= win_w[PL-1].im * win_w[PL-1].im;
		if (calc_done && ar_res.detect) begin
			offset_q <= fp_q;
			score_q  <= ar_res.score;
		end
		// hand the oldest captured sample to the output and rotate it to the head
		if (emit_load) begin
			m_pay_q   <= {cap_w[PL-1].im, cap_w[PL-1].re, score_q, offset_q};
			m_tlast_q <= cnt_last;
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = ncpd_pkg::M_TDATA_W'(m_pay_q);
	assign m_tlast   = m_tlast_q;
	assign cfg_ready = 1'b1;

	`ASSERT_AT(a_zero_power_zero_corr, clk, arst_n,
		((st_q == ncpd_pkg::ST_LAUNCH) && (pow_q == '0)) |-> ((acc_re_q == '0) && (acc_im_q == '0)))
	`ASSERT_AT(a_detect_emits, clk, arst_n, (calc_done && ar_res.detect) |=> (st_q == ncpd_pkg::ST_EMIT))
	`ASSERT_AT(a_last_on_final, clk, arst_n, emit_load |=> (m_tlast == $past(cnt_last)))
	`ASSERT_NEVER(a_no_input_busy, clk, arst_n, acc_in && (st_q != ncpd_pkg::ST_IDLE))

endmodule

// ===== test/normalized_correlation_preamble_detector_tb.sv =====
// Self-checking testbench of the normalized correlation preamble detector.
module normalized_correlation_preamble_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		ncpd_pkg::act_t                   action;
		logic [ncpd_pkg::TAP_W-1:0]       tap;
		logic signed [15:0]               re;
		logic signed [15:0]               im;
	} stream_item_t;

	typedef struct {
		logic [ncpd_pkg::OFS_W-1:0]       offset;
		logic [ncpd_pkg::SCORE_W-1:0]     score;
		logic [15:0]                      re;
		logic [15:0]                      im;
		logic                             last;
	} capture_word_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [ncpd_pkg::S_TDATA_W-1:0]       s_tdata;
	logic [ncpd_pkg::ACTION_W-1:0]        s_tuser;
	logic                                 m_tvalid;
	logic                                 m_tready;
	logic [ncpd_pkg::M_TDATA_W-1:0]       m_tdata;
	logic                                 m_tlast;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic                                 cfg_index;
	logic [ncpd_pkg::CFG_DATA_W-1:0]      cfg_data;

	normalized_correlation_preamble_detector dut (.*);

	// Predictor state: a private copy of what the block holds.
	logic signed [15:0] tap_re [ncpd_pkg::PREAMBLE_LEN];
	logic signed [15:0] tap_im [ncpd_pkg::PREAMBLE_LEN];
	logic signed [15:0] win_re [ncpd_pkg::PREAMBLE_LEN];
	logic signed [15:0] win_im [ncpd_pkg::PREAMBLE_LEN];
	logic signed [15:0] hist_re [ncpd_pkg::PREAMBLE_LEN];
	logic signed [15:0] hist_im [ncpd_pkg::PREAMBLE_LEN];
	int unsigned        hist_ptr;
	int unsigned        frame_pos;
	logic               locked;
	logic [15:0]        thr_reg;
	logic [12:0]        flen_reg;

	stream_item_t   pending_items[$];
	capture_word_t  expected_captures[$];
	stream_item_t   cur_item;
	logic           s_taken;
	logic           idle_on;
	int             s_gap;
	int             m_gap;
	int             errors;
	int             quiet_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Draw an idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Advance the detector state by one item and queue any burst it causes.
	task automatic detect_step(stream_item_t it);
		longint        cre, cim;
		logic [63:0]   pwr;
		logic [127:0]  num, rhs, cand;
		logic [15:0]   score;
		int unsigned   p, flen;
		capture_word_t w;
		case (it.action)
			ncpd_pkg::ACT_LOAD: begin
				tap_re[it.tap] = it.re;
				tap_im[it.tap] = it.im;
			end
			ncpd_pkg::ACT_CLEAR: begin
				for (int k = 0; k < ncpd_pkg::PREAMBLE_LEN; k++) begin
					win_re[k] = 0; win_im[k] = 0;
					hist_re[k] = 0; hist_im[k] = 0;
				end
				hist_ptr = 0;
				frame_pos = 0;
				locked = 1'b0;
			end
			ncpd_pkg::ACT_SAMPLE: begin
				for (int k = ncpd_pkg::PREAMBLE_LEN - 1; k > 0; k--) begin
					win_re[k] = win_re[k-1];
					win_im[k] = win_im[k-1];
				end
				win_re[0] = it.re;
				win_im[0] = it.im;
				if (!locked) begin
					hist_re[hist_ptr] = it.re;
					hist_im[hist_ptr] = it.im;
					hist_ptr = (hist_ptr + 1) % ncpd_pkg::PREAMBLE_LEN;
					cre = 0; cim = 0; pwr = 0;
					for (int k = 0; k < ncpd_pkg::PREAMBLE_LEN; k++) begin
						cre += longint'(tap_re[k]) * win_re[k] - longint'(tap_im[k]) * win_im[k];
						cim += longint'(tap_re[k]) * win_im[k] + longint'(tap_im[k]) * win_re[k];
						pwr += 64'(longint'(win_re[k]) * win_re[k])
							+ 64'(longint'(win_im[k]) * win_im[k]);
					end
					// N|c|^2 scaled by 4 to line up with the Q0.16 threshold squared
					num = (128'(mag64(cre)) * mag64(cre) + 128'(mag64(cim)) * mag64(cim))
						* ncpd_pkg::PREAMBLE_LEN * 4;
					rhs = 128'(pwr) * thr_reg * thr_reg;
					if (pwr != 0 && num > rhs) begin
						score = 0;
						for (int b = 15; b >= 0; b--) begin
							cand = 128'(score | (16'd1 << b));
							if (128'(pwr) * cand * cand <= num)
								score = cand[15:0];
						end
						p = hist_ptr;
						for (int k = 0; k < ncpd_pkg::PREAMBLE_LEN; k++) begin
							w.offset = frame_pos[ncpd_pkg::OFS_W-1:0];
							w.score = score;
							w.re = hist_re[p];
							w.im = hist_im[p];
							w.last = (k == ncpd_pkg::PREAMBLE_LEN - 1);
							expected_captures.push_back(w);
							p = (p + 1) % ncpd_pkg::PREAMBLE_LEN;
						end
						locked = 1'b1;
					end
				end
				flen = flen_reg;
				if (flen == 0)
					flen = 1;
				if (flen > ncpd_pkg::FLEN_MAX)
					flen = ncpd_pkg::FLEN_MAX;
				frame_pos++;
				if (frame_pos >= flen) begin
					frame_pos = 0;
					locked = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_item(ncpd_pkg::act_t a, int tap, int re, int im);
		stream_item_t it;
		it.action = a;
		it.tap = tap[ncpd_pkg::TAP_W-1:0];
		it.re = re[15:0];
		it.im = im[15:0];
		pending_items.push_back(it);
	endtask

	task automatic push_noise(int count);
		for (int i = 0; i < count; i++)
			push_item(ncpd_pkg::ACT_SAMPLE, $urandom, $urandom, $urandom);
	endtask

	// Send a preamble, newest lag last, first loading the matched template when reload is set.
	task automatic push_preamble(bit reload, bit noisy);
		int b, a, sr[ncpd_pkg::PREAMBLE_LEN], si[ncpd_pkg::PREAMBLE_LEN];
		b = $urandom_range(500, 32767);
		a = $urandom_range(200, 1600);
		for (int k = 0; k < ncpd_pkg::PREAMBLE_LEN; k++) begin
			sr[k] = $urandom_range(0, 1) ? 1 : -1;
			si[k] = $urandom_range(0, 1) ? 1 : -1;
			if (reload)
				push_item(ncpd_pkg::ACT_LOAD, k, sr[k] * a, -si[k] * a);
		end
		for (int k = ncpd_pkg::PREAMBLE_LEN - 1; k >= 0; k--)
			push_item(ncpd_pkg::ACT_SAMPLE, $urandom,
				sr[k] * b + (noisy ? $urandom_range(0, 400) - 200 : 0),
				si[k] * b + (noisy ? $urandom_range(0, 400) - 200 : 0));
	endtask

	// Random traffic mostly made of preamble runs with random content.
	task automatic push_traffic(int budget);
		int r;
		bit rl;
		while (budget > 0) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				rl = ($urandom_range(0, 3) == 0);
				push_preamble(rl, $urandom_range(0, 1));
				budget -= rl ? 2 * ncpd_pkg::PREAMBLE_LEN : ncpd_pkg::PREAMBLE_LEN;
			end else if (r < 85) begin
				push_noise(8);
				budget -= 8;
			end else if (r < 92) begin
				push_item(ncpd_pkg::ACT_LOAD, $urandom, $urandom, $urandom);
				budget--;
			end else if (r < 96) begin
				push_item(ncpd_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
				budget--;
			end else begin
				push_item(ncpd_pkg::ACT_NOP, $urandom, $urandom, $urandom);
				budget--;
			end
		end
	endtask

	// Hold until the stream is drained and every burst has come, then let the block settle.
	task automatic drain_wait();
		wait (pending_items.size() == 0 && !s_tvalid && expected_captures.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(ncpd_pkg::cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[ncpd_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == ncpd_pkg::CFG_THRESHOLD)
			thr_reg = value[15:0];
		else
			flen_reg = value[12:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Input driver: present the next transfer at the falling edge.
	always @(negedge clk) begin
		logic v;
		v = s_tvalid;
		if (s_taken) begin
			v = 1'b0;
			s_taken = 1'b0;
		end
		if (arst_n && !v) begin
			if (s_gap > 0) begin
				s_gap--;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				s_tdata <= {3'b0, cur_item.im, cur_item.re, cur_item.tap};
				s_tuser <= cur_item.action;
				v = 1'b1;
				s_gap = pick_gap();
			end
		end
		s_tvalid <= v;
	end

	// Output back-pressure.
	always @(negedge clk) begin
		if (m_gap > 0) begin
			m_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
			m_gap = pick_gap();
		end
	end

	// Monitor: predict on each input transfer, compare each result transfer.
	always @(posedge clk) begin
		capture_word_t w;
		logic moved;
		moved = 1'b0;
		if (arst_n && s_tvalid && s_tready) begin
			detect_step(cur_item);
			s_taken = 1'b1;
			moved = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			moved = 1'b1;
			if (expected_captures.size() == 0) begin
				$error("unexpected result transfer, tdata %h", m_tdata);
				errors++;
			end else begin
				w = expected_captures.pop_front();
				if (m_tdata[11:0] !== w.offset) begin
					$error("offset: expected %0d, got %0d", w.offset, m_tdata[11:0]);
					errors++;
				end
				if (m_tdata[27:12] !== w.score) begin
					$error("score: expected %0d, got %0d", w.score, m_tdata[27:12]);
					errors++;
				end
				if (m_tdata[43:28] !== w.re) begin
					$error("preamble_re: expected %h, got %h", w.re, m_tdata[43:28]);
					errors++;
				end
				if (m_tdata[59:44] !== w.im) begin
					$error("preamble_im: expected %h, got %h", w.im, m_tdata[59:44]);
					errors++;
				end
				if (m_tlast !== w.last) begin
					$error("last: expected %0d, got %0d", w.last, m_tlast);
					errors++;
				end
			end
		end
		if (arst_n && cfg_valid && cfg_ready)
			moved = 1'b1;
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("normalized_correlation_preamble_detector_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ncpd_pkg::CFG_THRESHOLD;
		cfg_data = '0;
		s_taken = 1'b0;
		idle_on = 1'b0;
		s_gap = 0;
		m_gap = 0;
		errors = 0;
		quiet_cycles = 0;
		thr_reg = 16'd52429;
		flen_reg = 13'd64;
		for (int k = 0; k < ncpd_pkg::PREAMBLE_LEN; k++) begin
			tap_re[k] = 0; tap_im[k] = 0;
			win_re[k] = 0; win_im[k] = 0;
			hist_re[k] = 0; hist_im[k] = 0;
		end
		hist_ptr = 0;
		frame_pos = 0;
		locked = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero power, unused action, extreme taps and samples, clear.
		push_item(ncpd_pkg::ACT_SAMPLE, 0, 0, 0);
		push_item(ncpd_pkg::ACT_NOP, 31, -1, -1);
		push_item(ncpd_pkg::ACT_LOAD, 0, -32768, 32767);
		push_item(ncpd_pkg::ACT_LOAD, 31, 32767, -32768);
		push_item(ncpd_pkg::ACT_SAMPLE, 31, 32767, 32767);
		push_item(ncpd_pkg::ACT_SAMPLE, 0, -32768, -32768);
		push_item(ncpd_pkg::ACT_SAMPLE, 5, 32767, -32768);
		push_item(ncpd_pkg::ACT_CLEAR, 0, 0, 0);
		push_item(ncpd_pkg::ACT_SAMPLE, 0, 0, 0);
		drain_wait();

		// Reset settings, no idling, then with idling.
		push_traffic(70);
		drain_wait();
		idle_on = 1'b1;
		push_traffic(60);
		drain_wait();

		// Lowest threshold and shortest frame: every sample with any correlation fires.
		write_reg(ncpd_pkg::CFG_THRESHOLD, 0);
		write_reg(ncpd_pkg::CFG_FRAME_LEN, 1);
		push_noise(20);
		push_item(ncpd_pkg::ACT_CLEAR, 0, 0, 0);
		push_noise(10);
		drain_wait();

		// Highest threshold and longest frame.
		write_reg(ncpd_pkg::CFG_THRESHOLD, 65535);
		write_reg(ncpd_pkg::CFG_FRAME_LEN, ncpd_pkg::FLEN_MAX);
		idle_on = 1'b0;
		push_traffic(70);
		drain_wait();

		// Out-of-range frame lengths: zero and above the maximum.
		write_reg(ncpd_pkg::CFG_THRESHOLD, $urandom_range(20000, 60000));
		write_reg(ncpd_pkg::CFG_FRAME_LEN, 0);
		idle_on = 1'b1;
		push_traffic(40);
		drain_wait();
		write_reg(ncpd_pkg::CFG_FRAME_LEN, 8191);
		push_traffic(40);
		drain_wait();

		// Random settings with moderate frames.
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(ncpd_pkg::CFG_THRESHOLD, $urandom_range(0, 65535));
			write_reg(ncpd_pkg::CFG_FRAME_LEN, $urandom_range(33, 200));
			idle_on = ph[0];
			push_traffic(50);
			drain_wait();
		end

		if (errors == 0)
			$display("normalized_correlation_preamble_detector_tb passed");
		else
			$display("normalized_correlation_preamble_detector_tb failed");
		$finish;
	end

endmodule

// ===== normalized_correlation_preamble_detector.f =====
+incdir+rtl/core
rtl/core/ncpd_pkg.sv
rtl/core/ncpd_cell.sv
rtl/core/ncpd_arith.sv
rtl/core/normalized_correlation_preamble_detector.sv
test/normalized_correlation_preamble_detector_tb.sv
